[rtl/gfta_pkg.sv]
// shared constants, widths and divider handshake types for the gated frame time average
// no dependencies; imported by gfta_div and the top module
package gfta_pkg;

	localparam int WINDOW_DEPTH = 32;

	localparam int FT_W   = 20;
	localparam int LEN_W  = 6;
	localparam int DEV_W  = 8;
	localparam int PER_W  = 20;
	localparam int ACC_W  = 21;
	localparam int CFG_W  = 20;
	localparam int CFG_IDX_W = 2;

	localparam int PTR_W  = $clog2(WINDOW_DEPTH);
	localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int IDX_W  = CNT_W + 1;
	localparam int SUM_W  = FT_W + PTR_W;
	localparam int LCMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam int SCL_W  = FT_W + CNT_W;
	localparam int DEVP_W = DEV_W + SUM_W;
	localparam int CMP_W  = (SCL_W + 3 > DEVP_W) ? SCL_W + 3 : DEVP_W;

	localparam int DIVD_W = SUM_W;
	localparam int DIVR_W = FT_W;
	localparam int DCNT_W = $clog2(DIVD_W);

	localparam logic [FT_W-1:0]  MILLION = FT_W'(1000000);
	localparam logic [ACC_W-1:0] ACC_MAX = '1;

	localparam logic [LEN_W-1:0] RST_WINDOW_LENGTH = LEN_W'(30);
	localparam logic [DEV_W-1:0] RST_DEVIATION     = DEV_W'(16);
	localparam logic [PER_W-1:0] RST_PERIOD        = PER_W'(500000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_LENGTH = 2'd0,
		CFG_DEVIATION     = 2'd1,
		CFG_PERIOD        = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

[rtl/gfta_ram.sv]
// generic single write port ram with one registered read port
// no dependencies
module gfta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/gfta_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
// depends on gfta_pkg for widths and the request/response structs
module gfta_div
	import gfta_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DIVR_W-1:0] divisor_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVD_W-1:0] quo_q;

	logic [DIVR_W:0]   trial;
	logic              qbit;
	logic [DIVR_W:0]   trial_sub;

	// shift next dividend bit into the partial remainder and try the subtract
	always_comb begin
		trial     = {rem_q, quo_q[DIVD_W-1]};
		trial_sub = trial - {1'b0, divisor_q};
		qbit      = (trial >= {1'b0, divisor_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DCNT_W'(DIVD_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DCNT_W'(1);
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			divisor_q <= req.divisor;
			rem_q     <= '0;
			quo_q     <= req.dividend;
		end else if (busy_q) begin
			rem_q <= qbit ? trial_sub[DIVR_W-1:0] : trial[DIVR_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], qbit};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

[rtl/gated_frame_time_average_top.sv]
// a zero average skips the second division
// each serial division in gfta_div yields one quotient bit a cycle over 25 bits
// throughput: one transaction in flight; the next is taken once the sequencer is back in idle with no
// report pending, or once a report enters the output register
// reset: arst_n asynchronous active low clears control state and loads register defaults
module gated_frame_time_average_top
	import gfta_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port, register index per cfg_reg_t
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,  // [19:0] frame_time_us, [23:20] zero
	// output stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata   // [19:0] avg_frame_us, [39:20] frames_per_second
);

	// one-hot sequencer states
	typedef enum logic [8:0] {
		ST_IDLE      = 9'b000000001,
		ST_GATE      = 9'b000000010,
		ST_DECIDE    = 9'b000000100,
		ST_EVICT_RD  = 9'b000001000,
		ST_EVICT_SUB = 9'b000010000,
		ST_APPEND    = 9'b000100000,
		ST_CHECK     = 9'b001000000,
		ST_DIV_AVG   = 9'b010000000,
		ST_DIV_FPS   = 9'b100000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [LEN_W-1:0] window_length_q;
	logic [DEV_W-1:0] deviation_q;
	logic [PER_W-1:0] period_q;

	// window state
	logic [PTR_W-1:0] wp_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic [ACC_W-1:0] acc_q;

	// working registers for the current transaction
	logic [FT_W-1:0]   x_q;
	logic [SCL_W-1:0]  scaled_q;
	logic [DEVP_W-1:0] devsum_q;
	logic [FT_W-1:0]   avg_q;
	logic              pend_q;     // report computed, waiting for the output register
	logic [FT_W-1:0]   fps_q;

	// output register
	logic              m_tvalid_q;
	logic [FT_W-1:0]   out_avg_q;
	logic [FT_W-1:0]   out_fps_q;

	// combinational helpers
	logic [LCMP_W-1:0] len_ext;
	logic [CNT_W-1:0]  len_eff;
	logic [SCL_W-1:0]  sum_ext;
	logic [SCL_W-1:0]  diff;
	logic [CMP_W-1:0]  diff8;
	logic              pass;
	logic [ACC_W:0]    acc_sum;
	logic [IDX_W-1:0]  oldest_full;
	logic [IDX_W-1:0]  oldest_idx;
	logic [PTR_W-1:0]  wp_next;
	logic              report;
	logic [FT_W-1:0]   avg_next;
	logic              out_load;

	logic [FT_W-1:0]   ram_rdata;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	// window length clipped into 1..WINDOW_DEPTH
	always_comb begin
		len_ext = LCMP_W'(window_length_q);
		if (window_length_q == '0) begin
			len_eff = CNT_W'(1);
		end else if (len_ext > LCMP_W'(WINDOW_DEPTH)) begin
			len_eff = CNT_W'(WINDOW_DEPTH);
		end else begin
			len_eff = CNT_W'(len_ext);
		end
	end

	// outlier gate: |x*count - sum|*8 < deviation*sum, empty window always passes
	always_comb begin
		sum_ext = SCL_W'(sum_q);
		diff    = (scaled_q >= sum_ext) ? scaled_q - sum_ext : sum_ext - scaled_q;
		diff8   = CMP_W'({diff, 3'b000});
		pass    = (count_q == '0) || (diff8 < CMP_W'(devsum_q));
	end

	// period accumulator saturates instead of wrapping
	assign acc_sum = (ACC_W+1)'(acc_q) + (ACC_W+1)'(x_q);

	// ring slot of the oldest entry
	always_comb begin
		oldest_full = IDX_W'(wp_q) + IDX_W'(WINDOW_DEPTH) - IDX_W'(count_q);
		if (oldest_full >= IDX_W'(WINDOW_DEPTH)) begin
			oldest_idx = oldest_full - IDX_W'(WINDOW_DEPTH);
		end else begin
			oldest_idx = oldest_full;
		end
	end

	assign wp_next = (wp_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
	assign report  = acc_q > ACC_W'(period_q);

	// empty window would divide by zero, the average then reads as zero
	assign avg_next = (count_q == '0) ? '0 : div_rsp.quotient[FT_W-1:0];

	// shared divider: sum/count first, then million/average
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = DIVD_W'(MILLION);
		div_req.divisor  = avg_next;
		if (state_q == ST_CHECK) begin
			div_req.start    = report;
			div_req.dividend = sum_q;
			div_req.divisor  = DIVR_W'(count_q);
		end else if (state_q == ST_DIV_AVG) begin
			div_req.start = div_rsp.done && (avg_next != '0);
		end
	end

	// finished report moves into the output register once that is free
	assign out_load = pend_q && (!m_tvalid_q || m_tready);

	assign s_tready = (state_q == ST_IDLE) && !pend_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= RST_WINDOW_LENGTH;
			deviation_q     <= RST_DEVIATION;
			period_q        <= RST_PERIOD;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WINDOW_LENGTH: window_length_q <= cfg_data[LEN_W-1:0];
				CFG_DEVIATION:     deviation_q     <= cfg_data[DEV_W-1:0];
				CFG_PERIOD:        period_q        <= cfg_data[PER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wp_q    <= '0;
			count_q <= '0;
			sum_q   <= '0;
			acc_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			if (out_load) begin
				pend_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						state_q <= ST_GATE;
					end
				end
				ST_GATE: begin
					acc_q   <= acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (!pass) begin
						state_q <= ST_CHECK;
					end else if (count_q >= len_eff) begin
						state_q <= ST_EVICT_RD;
					end else begin
						state_q <= ST_APPEND;
					end
				end
				ST_EVICT_RD: begin
					state_q <= ST_EVICT_SUB;
				end
				ST_EVICT_SUB: begin
					sum_q   <= sum_q - SUM_W'(ram_rdata);
					count_q <= count_q - CNT_W'(1);
					// keep evicting while the window is still at or over the length
					state_q <= (count_q > len_eff) ? ST_EVICT_RD : ST_APPEND;
				end
				ST_APPEND: begin
					wp_q    <= wp_next;
					count_q <= count_q + CNT_W'(1);
					sum_q   <= sum_q + SUM_W'(x_q);
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (report) begin
						acc_q   <= acc_q - ACC_W'(period_q);
						state_q <= ST_DIV_AVG;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV_AVG: begin
					if (div_rsp.done) begin
						if (avg_next == '0) begin
							pend_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_DIV_FPS;
						end
					end
				end
				ST_DIV_FPS: begin
					if (div_rsp.done) begin
						pend_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			x_q <= s_tdata[FT_W-1:0];
		end
		if (state_q == ST_GATE) begin
			scaled_q <= SCL_W'(x_q) * SCL_W'(count_q);
			devsum_q <= DEVP_W'(deviation_q) * DEVP_W'(sum_q);
		end
		if (state_q == ST_DIV_AVG && div_rsp.done) begin
			avg_q <= avg_next;
			if (avg_next == '0) begin
				fps_q <= MILLION;
			end
		end
		if (state_q == ST_DIV_FPS && div_rsp.done) begin
			fps_q <= div_rsp.quotient[FT_W-1:0];
		end
		if (out_load) begin
			out_avg_q <= avg_q;
			out_fps_q <= fps_q;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_fps_q, out_avg_q};

	// ring store of window samples
	gfta_ram #(
		.WIDTH (FT_W),
		.DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (state_q == ST_APPEND),
		.waddr (wp_q),
		.wdata (x_q),
		.re    (state_q == ST_EVICT_RD),
		.raddr (oldest_idx[PTR_W-1:0]),
		.rdata (ram_rdata)
	);

	// serial divider for average and frames per second
	gfta_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

`ifndef SYNTHESIS
	// window never holds more entries than the store has slots
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(WINDOW_DEPTH))
		else $error("entry count beyond window depth");

	// eviction only ever happens on a non-empty window
	a_evict_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVICT_SUB) |-> (count_q != '0))
		else $error("eviction from empty window");

	// divider results only arrive while the sequencer waits for them
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV_AVG || state_q == ST_DIV_FPS))
		else $error("divider done outside a division state");

	// new output transaction only from a pending report
	a_out_from_pend: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(pend_q))
		else $error("output valid without pending report");
`endif

endmodule
